// ----- src/assert_macros.svh -----
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms used by the bar graph renderer modules.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SBG_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define SBG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define SBG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sbg_pkg.sv -----
// ============================================================================
// Spectrum bar graph package
// Sizes, state types, control structs and the color ramp shared by the
// bar graph renderer modules.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package sbg_pkg;

    // Frame geometry.
    localparam int BINS    = 16;
    localparam int ROWS    = 8;
    localparam int COLUMNS = 32;

    // Field widths fixed by the stream format.
    localparam int MAG_W       = 16;
    localparam int COLOR_W     = 24;
    localparam int CH_W        = 8;
    localparam int LED_FIELDS  = 8;
    localparam int COL_FIELD_W = 5;

    // Derived widths.
    localparam int BIN_W  = $clog2(BINS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int BIN_IW = (COL_W > BIN_W + 1) ? COL_W : BIN_W + 1;
    localparam int HGT_W  = $clog2(ROWS + 1);
    localparam int QUO_W  = $clog2(ROWS);
    localparam int NUM_W  = MAG_W + HGT_W;
    localparam int STP_W  = $clog2(QUO_W + 1);

    // Output stream packing.
    localparam int OUT_FIELDS_W = COL_FIELD_W + LED_FIELDS * COLOR_W + COLOR_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    // Color ramp constants.
    localparam int RAMP_IW = 4;
    localparam logic [RAMP_IW-1:0] RAMP_MAX  = 4'd15;
    localparam logic [CH_W-1:0]    FULL      = 8'hFF;
    localparam logic [CH_W-1:0]    RAMP_STEP = 8'd63;

    // Ramp bands, selected by the upper two bits of the ramp index.
    localparam logic [1:0] BAND_BLUE_UP   = 2'd0;
    localparam logic [1:0] BAND_RED_DOWN  = 2'd1;
    localparam logic [1:0] BAND_GREEN_UP  = 2'd2;
    localparam logic [1:0] BAND_BLUE_DOWN = 2'd3;

    // Top level sequencer states.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_COL,
        ST_WAIT,
        ST_EMIT
    } sbg_state_t;

    // Height divider phases.
    typedef enum logic [1:0] {
        DP_IDLE,
        DP_SAT,
        DP_STEP
    } sbg_div_phase_t;

    // Request from the sequencer to the height divider.
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] magnitude;
        logic [MAG_W-1:0] peak;
    } div_req_t;

    // Status from the height divider to the sequencer.
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [HGT_W-1:0] height;
    } div_stat_t;

    // Bar color ramp: red to blue to green over index 0 to 15.
    function automatic logic [COLOR_W-1:0] ramp_colour(input logic [RAMP_IW-1:0] idx);
        logic [CH_W-1:0] s;
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        s = CH_W'(CH_W'(idx[1:0]) * RAMP_STEP);
        case (idx[3:2])
            BAND_BLUE_UP:   begin r = FULL;     g = '0;       b = s;        end
            BAND_RED_DOWN:  begin r = FULL - s; g = '0;       b = FULL;     end
            BAND_GREEN_UP:  begin r = '0;       g = s;        b = FULL;     end
            default:        begin r = '0;       g = FULL;     b = FULL - s; end
        endcase
        return {r, g, b};
    endfunction

    // Background color: red takes blue, green takes red, blue takes green.
    function automatic logic [COLOR_W-1:0] rotate_colour(input logic [COLOR_W-1:0] c);
        return {c[CH_W-1:0], c[3*CH_W-1:2*CH_W], c[2*CH_W-1:CH_W]};
    endfunction

endpackage

`default_nettype wire

// ----- src/sbg_cmpsub.sv -----
// ============================================================================
// Compare and subtract unit
// Shared arithmetic step of the height divider: compares a partial
// remainder against the divisor and forms their difference.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sbg_cmpsub
    import sbg_pkg::*;
(
    input  logic [MAG_W:0]   a,
    input  logic [MAG_W-1:0] b,
    output logic             ge,
    output logic [MAG_W:0]   diff
);

    // One wide subtract; the borrow gives the compare.
    logic [MAG_W+1:0] sub;

    assign sub  = {1'b0, a} - {2'b00, b};
    assign ge   = ~sub[MAG_W+1];
    assign diff = sub[MAG_W:0];

endmodule

`default_nettype wire

// ----- src/sbg_height_div.sv -----
// ============================================================================
// Bar height divider
// Iterative restoring divider that forms floor(ROWS * magnitude / peak),
// clipped to ROWS, one quotient bit per cycle on a shared compare-subtract.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sbg_height_div
    import sbg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_req_t  req,   // peak must stay stable while busy
    output div_stat_t stat
);

    sbg_div_phase_t    phase_reg, phase_next;
    logic              done_reg, done_next;
    logic [HGT_W-1:0]  height_reg, height_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [MAG_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  qsh_reg, qsh_next;
    logic [STP_W-1:0]  step_reg, step_next;

    logic [MAG_W:0]    cmp_a;
    logic              cmp_ge;
    logic [MAG_W:0]    cmp_diff;

    // Shared compare-subtract unit.
    sbg_cmpsub u_cmpsub (
        .a    (cmp_a),
        .b    (req.peak),
        .ge   (cmp_ge),
        .diff (cmp_diff)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= DP_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        height_reg <= height_next;
        mag_reg    <= mag_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        qsh_reg    <= qsh_next;
    end

    // Sequencing: saturation check first, then one quotient bit per cycle.
    // The low quotient bits of the dividend shift out of qsh_reg at the top
    // while quotient bits shift in at the bottom.
    always_comb
    begin
        phase_next  = phase_reg;
        done_next   = 1'b0;
        height_next = height_reg;
        mag_next    = mag_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        qsh_next    = qsh_reg;
        step_next   = step_reg;
        cmp_a       = {rem_reg, qsh_reg[QUO_W-1]};

        case (phase_reg)
            DP_IDLE:
            begin
                if (req.start)
                begin
                    if (req.peak == '0)
                    begin
                        // Zero peak: every bar is empty.
                        height_next = '0;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        mag_next   = req.magnitude;
                        num_next   = NUM_W'(req.magnitude) * NUM_W'(ROWS);
                        phase_next = DP_SAT;
                    end
                end
            end

            DP_SAT:
            begin
                cmp_a = {1'b0, mag_reg};
                if (cmp_ge)
                begin
                    // Magnitude at or above the peak fills the whole bar.
                    height_next = HGT_W'(ROWS);
                    done_next   = 1'b1;
                    phase_next  = DP_IDLE;
                end
                else
                begin
                    rem_next   = MAG_W'(num_reg >> QUO_W);
                    qsh_next   = num_reg[QUO_W-1:0];
                    step_next  = STP_W'(QUO_W);
                    phase_next = DP_STEP;
                end
            end

            DP_STEP:
            begin
                rem_next  = cmp_ge ? cmp_diff[MAG_W-1:0] : cmp_a[MAG_W-1:0];
                qsh_next  = (qsh_reg << 1) | QUO_W'(cmp_ge);
                step_next = step_reg - STP_W'(1);
                if (step_reg == STP_W'(1))
                begin
                    height_next = HGT_W'(qsh_next);
                    done_next   = 1'b1;
                    phase_next  = DP_IDLE;
                end
            end

            default:
            begin
                phase_next = DP_IDLE;
            end
        endcase
    end

    assign stat.busy   = (phase_reg != DP_IDLE);
    assign stat.done   = done_reg;
    assign stat.height = height_reg;

    // A new request only arrives while the divider is idle.
    `SBG_ASSERT_IMPL(a_start_idle, clk, rst_n, req.start, phase_reg == DP_IDLE, "divider started while busy")
    // A finished height never exceeds the bar length.
    `SBG_ASSERT_IMPL(a_height_range, clk, rst_n, done_reg, height_reg <= HGT_W'(ROWS), "bar height above ROWS")

endmodule

`default_nettype wire

// ----- src/spectrum_bar_graph_renderer.sv -----
// ============================================================================
// Spectrum bar graph renderer
// Loads a frame of spectrum magnitudes, finds the peak, and streams one
// column of LED colors per output transaction for a serpentine LED matrix.
// ============================================================================
// The block takes BINS magnitudes, one per input transaction at one per
// cycle, then stops taking input and streams COLUMNS output transactions,
// one per matrix column; tlast marks the last column. Each pair of columns
// shows one bin, whose bar height comes from an iterative divider built on
// a single compare-subtract unit: one saturation check, then one step per
// quotient bit. An even column starts the divider; an odd column reuses
// the height of the column before it.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module spectrum_bar_graph_renderer
    import sbg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [MAG_W-1:0]      s_tdata,   // [15:0] magnitude
    // Output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // column, led_0..led_7, strip_color, zero pad
    output logic                  m_tlast    // frame_end
);

    sbg_state_t        state_reg, state_next;
    logic [BIN_W-1:0]  cnt_reg, cnt_next;
    logic [MAG_W-1:0]  peak_value_reg, peak_value_next;
    logic [BIN_W-1:0]  peak_bin_reg, peak_bin_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [HGT_W-1:0]  height_reg, height_next;
    logic [MAG_W-1:0]  bin_store [BINS];
    logic [MAG_W-1:0]  mag_rd_reg;

    logic              in_xfer;
    logic              out_xfer;
    logic [BIN_IW-1:0] bin_ext;
    logic [BIN_IW-1:0] bin_next_ext;
    logic              bin_valid;
    logic              div_start;
    div_req_t          div_req;
    div_stat_t         div_stat;

    logic [RAMP_IW-1:0]                   ramp_idx;
    logic [COLOR_W-1:0]                   bar_color;
    logic [COLOR_W-1:0]                   back_color;
    logic [LED_FIELDS-1:0][COLOR_W-1:0]   led;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // Bin shown by the current column and by the column that follows.
    assign bin_ext      = BIN_IW'(col_reg >> 1);
    assign bin_next_ext = BIN_IW'(col_next >> 1);
    assign bin_valid    = (bin_ext < BIN_IW'(BINS));

    // Bin magnitude storage, written in arrival order. The read follows the
    // next column so the magnitude is ready when that column starts.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            bin_store[cnt_reg] <= s_tdata;
        end
        mag_rd_reg <= bin_store[bin_next_ext[BIN_W-1:0]];
    end

    // Height divider.
    assign div_req.start     = div_start;
    assign div_req.magnitude = mag_rd_reg;
    assign div_req.peak      = peak_value_reg;

    sbg_height_div u_height_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    // Sequencer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            cnt_reg        <= '0;
            peak_value_reg <= '0;
            peak_bin_reg   <= BIN_W'(1);
            col_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            peak_value_reg <= peak_value_next;
            peak_bin_reg   <= peak_bin_next;
            col_reg        <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        height_reg <= height_next;
    end

    // Next state and handshake outputs.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        peak_value_next = peak_value_reg;
        peak_bin_next   = peak_bin_reg;
        col_next        = col_reg;
        height_next     = height_reg;
        div_start       = 1'b0;
        s_tready        = 1'b0;
        m_tvalid        = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (in_xfer)
                begin
                    // Bin 0 never counts toward the peak; ties keep the earlier bin.
                    if ((cnt_reg != '0) && (s_tdata > peak_value_reg))
                    begin
                        peak_value_next = s_tdata;
                        peak_bin_next   = cnt_reg;
                    end
                    if (cnt_reg == BIN_W'(BINS - 1))
                    begin
                        cnt_next   = '0;
                        col_next   = '0;
                        state_next = ST_COL;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + BIN_W'(1);
                    end
                end
            end

            ST_COL:
            begin
                // An even column starts a new bin; an odd one reuses its height.
                if (!col_reg[0])
                begin
                    if (bin_valid)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_WAIT;
                    end
                    else
                    begin
                        height_next = '0;
                        state_next  = ST_EMIT;
                    end
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_WAIT:
            begin
                if (div_stat.done)
                begin
                    height_next = div_stat.height;
                    state_next  = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                if (out_xfer)
                begin
                    if (m_tlast)
                    begin
                        // Frame done: peak tracking returns to its reset values.
                        peak_value_next = '0;
                        peak_bin_next   = BIN_W'(1);
                        col_next        = '0;
                        state_next      = ST_LOAD;
                    end
                    else
                    begin
                        col_next   = col_reg + COL_W'(1);
                        state_next = ST_COL;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Bar and background colors from the peak bin, index saturated at 15.
    assign ramp_idx   = (peak_bin_reg > BIN_W'(RAMP_MAX)) ? RAMP_MAX : RAMP_IW'(peak_bin_reg);
    assign bar_color  = ramp_colour(ramp_idx);
    assign back_color = rotate_colour(bar_color);

    // LED colors with serpentine row order: rows count down on even columns.
    for (genvar k = 0; k < LED_FIELDS; k++)
    begin : g_led
        if (k < ROWS)
        begin : g_used
            localparam logic [HGT_W-1:0] ROW_EVEN = HGT_W'(ROWS - 1 - k);
            localparam logic [HGT_W-1:0] ROW_ODD  = HGT_W'(k);
            logic [HGT_W-1:0] row;
            assign row    = col_reg[0] ? ROW_ODD : ROW_EVEN;
            assign led[k] = (row < height_reg) ? bar_color : back_color;
        end
        else
        begin : g_unused
            assign led[k] = '0;
        end
    end

    // Output payload.
    assign m_tdata = {{OUT_PAD_W{1'b0}}, bar_color, led, COL_FIELD_W'(col_reg)};
    assign m_tlast = (col_reg == COL_W'(COLUMNS - 1));

    // Loading and rendering never overlap.
    `SBG_ASSERT_ALWAYS(a_load_emit_excl, clk, rst_n, !(s_tready && m_tvalid), "input and output active together")
    // Accepting the last column returns to loading with the peak cleared.
    `SBG_ASSERT_NEXT(a_frame_restart, clk, rst_n, out_xfer && m_tlast, (state_reg == ST_LOAD) && (peak_value_reg == '0) && (cnt_reg == '0), "frame did not restart")
    // A shown bar never exceeds the column height.
    `SBG_ASSERT_IMPL(a_bar_range, clk, rst_n, m_tvalid, height_reg <= HGT_W'(ROWS), "bar height above ROWS")

endmodule

`default_nettype wire

// ----- verif/spectrum_bar_graph_renderer_tb.sv -----
// ============================================================================
// Spectrum bar graph renderer testbench
// Streams frames of bin magnitudes into the renderer and checks every column
// transaction against a cycle-free prediction of peak search, color ramp and
// bar heights. Directed frames cover the corner cases; random frames follow
// under three flow-control profiles.
// ============================================================================
`timescale 1ns / 1ps

module spectrum_bar_graph_renderer_tb;
    import sbg_pkg::*;

    // Ramp constants for the predicted bar color.
    localparam logic [7:0] CH_FULL  = 8'hFF;
    localparam int         RAMP_INC = 63;
    localparam int         FRAMES_PER_PHASE = 3;
    localparam int         DRAIN_CYCLES     = 100;
    localparam int         STRIP_LSB        = COL_FIELD_W + LED_FIELDS * COLOR_W;

    // One predicted column of the LED matrix.
    typedef struct packed {
        logic [COL_FIELD_W-1:0]                column;
        logic [LED_FIELDS-1:0][COLOR_W-1:0]    leds;
        logic [COLOR_W-1:0]                    strip;
        logic                                  frame_end;
    } column_t;

    // Frame predictor and column checker.
    class column_scoreboard;
        column_t     expected_columns[$];
        int unsigned bin_mags[BINS];
        int unsigned bin_count;
        int unsigned peak_value;
        int unsigned peak_bin;
        int          failures;

        function new();
            bin_count  = 0;
            peak_value = 0;
            peak_bin   = 1;
            failures   = 0;
        endfunction

        function int pending();
            return expected_columns.size();
        endfunction

        // Red-blue-green ramp, four bands of four steps.
        function logic [COLOR_W-1:0] bar_color(int unsigned idx);
            if (idx > 15)
                idx = 15;
            if (idx < 4)
                return {CH_FULL, 8'h00, 8'(idx * RAMP_INC)};
            if (idx < 8)
                return {8'(255 - (idx - 4) * RAMP_INC), 8'h00, CH_FULL};
            if (idx < 12)
                return {8'h00, 8'((idx - 8) * RAMP_INC), CH_FULL};
            return {8'h00, CH_FULL, 8'(255 - (idx - 12) * RAMP_INC)};
        endfunction

        // Accepted bin: update the peak and, on the last bin, queue a frame.
        function void note_bin(logic [MAG_W-1:0] mag);
            column_t          col;
            logic [COLOR_W-1:0] bar;
            logic [COLOR_W-1:0] back;
            int unsigned      h;
            int unsigned      row;
            bin_mags[bin_count] = mag;
            if (bin_count >= 1 && mag > peak_value) begin
                peak_value = mag;
                peak_bin   = bin_count;
            end
            bin_count++;
            if (bin_count < BINS)
                return;
            bar  = bar_color(peak_bin);
            // Background: red takes blue, green takes red, blue takes green.
            back = {bar[7:0], bar[23:16], bar[15:8]};
            for (int c = 0; c < COLUMNS; c++) begin
                if (c / 2 >= BINS || peak_value == 0)
                    h = 0;
                else
                    h = (ROWS * bin_mags[c / 2]) / peak_value;
                if (h > ROWS)
                    h = ROWS;
                col.column = COL_FIELD_W'(c);
                for (int k = 0; k < LED_FIELDS; k++) begin
                    // Serpentine wiring: even columns run top-down in strip order.
                    row = (c % 2 == 1) ? k : ROWS - 1 - k;
                    if (k >= ROWS)
                        col.leds[k] = '0;
                    else
                        col.leds[k] = (row < h) ? bar : back;
                end
                col.strip     = bar;
                col.frame_end = (c == COLUMNS - 1);
                expected_columns.push_back(col);
            end
            bin_count  = 0;
            peak_value = 0;
            peak_bin   = 1;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s expected %0h actual %0h", name, want, got);
                failures++;
            end
        endfunction

        // Accepted column transaction: compare with the oldest prediction.
        function void check_column(logic [OUT_DATA_W-1:0] data, logic last);
            column_t want;
            if (expected_columns.size() == 0) begin
                $error("column transaction with nothing expected, column %0d",
                       data[COL_FIELD_W-1:0]);
                failures++;
                return;
            end
            want = expected_columns.pop_front();
            compare_field("column", want.column, data[COL_FIELD_W-1:0]);
            for (int k = 0; k < LED_FIELDS; k++)
                compare_field($sformatf("led_%0d", k), want.leds[k],
                              data[COL_FIELD_W + k * COLOR_W +: COLOR_W]);
            compare_field("strip_color", want.strip, data[STRIP_LSB +: COLOR_W]);
            compare_field("frame_end", want.frame_end, last);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [MAG_W-1:0]      s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    column_scoreboard      sb;
    int                    tx_idle_pct = 0;
    int                    rx_idle_pct = 0;
    logic [MAG_W-1:0]      frame_bins [BINS];

    spectrum_bar_graph_renderer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Output side: random back-pressure.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Check every accepted output transaction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_column(m_tdata, m_tlast);
    end

    // Send one bin, with random idle cycles ahead of it.
    task automatic send_bin(input logic [MAG_W-1:0] mag);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mag;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_bin(mag);
    endtask

    task automatic send_frame();
        for (int b = 0; b < BINS; b++)
            send_bin(frame_bins[b]);
    endtask

    // Hold the input quiet until every predicted column has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Random frame: fully random, a planted peak, or small magnitudes.
    task automatic fill_random_frame();
        int          mode;
        int unsigned pb;
        int unsigned pv;
        mode = $urandom_range(2);
        pb   = $urandom_range(BINS - 1, 1);
        pv   = $urandom_range(65535, 1);
        for (int b = 0; b < BINS; b++) begin
            case (mode)
                0:       frame_bins[b] = MAG_W'($urandom);
                1:       frame_bins[b] = (b == pb) ? MAG_W'(pv)
                                       : (b == 0) ? MAG_W'($urandom)
                                       : MAG_W'($urandom_range(pv, 0));
                default: frame_bins[b] = MAG_W'($urandom_range(9));
            endcase
        end
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin tx_idle_pct = 16; rx_idle_pct = 52; end
                1:       begin tx_idle_pct = 52; rx_idle_pct = 16; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase

            if (phase == 0) begin
                // Zero peak: bin 0 at full scale but every other bin empty.
                foreach (frame_bins[b])
                    frame_bins[b] = '0;
                frame_bins[0] = 16'hFFFF;
                send_frame();

                // Bin 0 above the peak, a tie for the peak, and heights 0 to 5 and 8.
                foreach (frame_bins[b])
                    frame_bins[b] = MAG_W'(b * 16'h0C00);
                frame_bins[0]  = 16'hFFFF;
                frame_bins[1]  = 16'h0001;
                frame_bins[5]  = 16'hC000;
                frame_bins[9]  = 16'hC000;
                frame_bins[12] = 16'h6000;
                frame_bins[13] = 16'h5FFF;
                frame_bins[14] = 16'h0000;
                frame_bins[15] = 16'h1800;
                send_frame();
            end

            for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
                fill_random_frame();
                send_frame();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0)
            $display("spectrum_bar_graph_renderer_tb OK");
        else
            $display("spectrum_bar_graph_renderer_tb NOT OK");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("spectrum_bar_graph_renderer_tb NOT OK");
        $finish;
    end

endmodule
